// ----- hw/rtl/ism_pkg.sv -----
// Types and constants shared by the interval sort and merge block.
`default_nettype none

package ism_pkg;

  localparam int FIELD_BITS = 16;

  typedef struct packed {
    logic [FIELD_BITS-1:0] start_point;
    logic [FIELD_BITS-1:0] end_point;
    logic                  final_item;
  } ism_in_t;

  typedef struct packed {
    logic [FIELD_BITS-1:0] merged_start;
    logic [FIELD_BITS-1:0] merged_end;
    logic                  final_result;
    logic                  overflowed;
  } ism_out_t;

  // controller to datapath
  typedef struct packed {
    logic insert;     // put the input interval into the sorted chain
    logic pop;        // take the head of the chain into the merge registers
    logic emit;       // load the output register from the merge registers
    logic emit_last;  // the emitted interval closes the set
    logic clr;        // end of set: drop merge state and overflow flag
  } ism_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic head_valid;  // chain holds at least one interval
    logic head_joins;  // head start lies within the running merged interval
    logic cur_valid;   // merge registers hold an interval
    logic out_busy;    // output register full and stalled
  } ism_sts_t;

endpackage

`default_nettype wire

// ----- hw/rtl/ism_ctrl.sv -----
// Controller state machine: load phase and merge/emit phase.
`default_nettype none

module ism_ctrl (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              in_valid,
  input  wire              in_final,
  output logic             in_stall,
  input  ism_pkg::ism_sts_t sts,
  output ism_pkg::ism_cmd_t cmd
);
  import ism_pkg::*;

  localparam logic ST_LOAD  = 1'b0;
  localparam logic ST_MERGE = 1'b1;

  logic state_r, state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_stall  = 1'b1;
    unique case (state_r)
      ST_LOAD: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.insert = 1'b1;
          if (in_final) state_nxt = ST_MERGE;
        end
      end
      ST_MERGE: begin
        if (sts.head_valid) begin
          if (sts.cur_valid && !sts.head_joins) begin
            // a gap closes the running interval; it must leave first
            if (!sts.out_busy) begin
              cmd.pop  = 1'b1;
              cmd.emit = 1'b1;
            end
          end else begin
            cmd.pop = 1'b1;
          end
        end else if (sts.cur_valid) begin
          if (!sts.out_busy) begin
            cmd.emit      = 1'b1;
            cmd.emit_last = 1'b1;
            cmd.clr       = 1'b1;
            state_nxt     = ST_LOAD;
          end
        end else begin
          cmd.clr   = 1'b1;
          state_nxt = ST_LOAD;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_LOAD;
    else        state_r <= state_nxt;
  end

  a_no_load_in_merge: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MERGE) |-> (in_stall && !cmd.insert))
    else $error("input taken during merge phase");

endmodule

`default_nettype wire

// ----- hw/rtl/ism_dp.sv -----
// Datapath: sorted insertion chain, merge registers and output register.
`default_nettype none

module ism_dp #(
  parameter int MAX_INTERVALS = 64,
  parameter int COORD_BITS    = 16
) (
  input  wire               clk,
  input  wire               rst_n,
  input  ism_pkg::ism_in_t  in_data,
  input  ism_pkg::ism_cmd_t cmd,
  output ism_pkg::ism_sts_t sts,
  input  wire               out_stall,
  output logic              out_valid,
  output ism_pkg::ism_out_t out_data
);
  import ism_pkg::*;

  logic [MAX_INTERVALS-1:0] vld_r, vld_nxt;
  logic [MAX_INTERVALS-1:0] ins;
  logic [COORD_BITS-1:0]    lo_r  [MAX_INTERVALS];
  logic [COORD_BITS-1:0]    hi_r  [MAX_INTERVALS];
  logic [COORD_BITS-1:0]    lo_nxt[MAX_INTERVALS];
  logic [COORD_BITS-1:0]    hi_nxt[MAX_INTERVALS];

  logic [COORD_BITS-1:0] new_lo, new_hi, raw_hi;
  logic [COORD_BITS-1:0] cur_lo_r, cur_hi_r;
  logic                  cur_valid_r;
  logic                  ovf_r;
  logic                  out_valid_r;
  ism_out_t              out_data_r;
  logic                  full;

  assign new_lo = COORD_BITS'(in_data.start_point);
  assign raw_hi = COORD_BITS'(in_data.end_point);
  assign new_hi = (raw_hi < new_lo) ? new_lo : raw_hi;
  assign full   = vld_r[MAX_INTERVALS-1];

  // Each cell decides on its own: it yields when empty or holding a larger start.
  // Equal starts stay ahead of the newcomer. A full chain drops the newcomer.
  for (genvar g = 0; g < MAX_INTERVALS; g++) begin : g_cell
    assign ins[g] = !vld_r[g] || (lo_r[g] > new_lo);

    always_comb begin
      lo_nxt[g] = lo_r[g];
      hi_nxt[g] = hi_r[g];
      if (cmd.insert && !full && ins[g]) begin
        if (g == 0) begin
          lo_nxt[g] = new_lo;
          hi_nxt[g] = new_hi;
        end else if (!ins[(g == 0) ? 0 : g-1]) begin
          lo_nxt[g] = new_lo;
          hi_nxt[g] = new_hi;
        end else begin
          lo_nxt[g] = lo_r[(g == 0) ? 0 : g-1];
          hi_nxt[g] = hi_r[(g == 0) ? 0 : g-1];
        end
      end else if (cmd.pop && (g < MAX_INTERVALS-1)) begin
        lo_nxt[g] = lo_r[(g < MAX_INTERVALS-1) ? g+1 : g];
        hi_nxt[g] = hi_r[(g < MAX_INTERVALS-1) ? g+1 : g];
      end
    end

    always_ff @(posedge clk) begin
      lo_r[g] <= lo_nxt[g];
      hi_r[g] <= hi_nxt[g];
    end
  end

  always_comb begin
    vld_nxt = vld_r;
    if (cmd.insert && !full) vld_nxt = {vld_r[MAX_INTERVALS-2:0], 1'b1};
    else if (cmd.pop)        vld_nxt = {1'b0, vld_r[MAX_INTERVALS-1:1]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      cur_valid_r <= 1'b0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
      if (cmd.clr)       cur_valid_r <= 1'b0;
      else if (cmd.pop)  cur_valid_r <= 1'b1;
      if (cmd.clr)                  ovf_r <= 1'b0;
      else if (cmd.insert && full)  ovf_r <= 1'b1;
      if (cmd.emit)          out_valid_r <= 1'b1;
      else if (!out_stall)   out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pop) begin
      if (!cur_valid_r || cmd.emit) begin
        cur_lo_r <= lo_r[0];
        cur_hi_r <= hi_r[0];
      end else if (hi_r[0] > cur_hi_r) begin
        cur_hi_r <= hi_r[0];
      end
    end
    if (cmd.emit) begin
      out_data_r.merged_start <= FIELD_BITS'(cur_lo_r);
      out_data_r.merged_end   <= FIELD_BITS'(cur_hi_r);
      out_data_r.final_result <= cmd.emit_last;
      out_data_r.overflowed   <= ovf_r;
    end
  end

  assign sts.head_valid = vld_r[0];
  assign sts.head_joins = (lo_r[0] <= cur_hi_r);
  assign sts.cur_valid  = cur_valid_r;
  assign sts.out_busy   = out_valid_r && out_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // occupied cells always form a run from the head
  a_chain_packed: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r & (vld_r + 1'b1)) == '0)
    else $error("hole in insertion chain");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !(out_valid_r && out_stall))
    else $error("result overwritten while stalled");

  a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[0] && vld_r[1]) |-> (lo_r[0] <= lo_r[1]))
    else $error("chain head out of order");

  a_clr_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clr |=> !ovf_r)
    else $error("overflow flag survives end of set");

endmodule

`default_nettype wire

// ----- hw/rtl/interval_sort_merge_top.sv -----
// Top level of the interval sort and merge block.
// Load: one interval per cycle; each is placed into a sorted insertion chain on arrival.
// After the final interval the chain drains one entry per cycle through the merge
// registers, except while a closed interval waits on a stalled output register.
// Results leave through an output register, at most one per cycle; input stalls meanwhile.
// Synchronous active-low reset clears the chain valid bits, flags and state machine.
`default_nettype none

module interval_sort_merge_top #(
  parameter int MAX_INTERVALS = 64,
  parameter int COORD_BITS    = 16
) (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  output logic              in_stall,
  input  ism_pkg::ism_in_t  in_data,
  output logic              out_valid,
  input  wire               out_stall,
  output ism_pkg::ism_out_t out_data
);
  import ism_pkg::*;

  ism_cmd_t cmd;
  ism_sts_t sts;

  ism_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_final (in_data.final_item),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  ism_dp #(
    .MAX_INTERVALS (MAX_INTERVALS),
    .COORD_BITS    (COORD_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ----- test/interval_sort_merge_checker.sv -----
// Checker for the interval sort and merge block: predicts merged intervals and scores results.
`default_nettype none

module interval_sort_merge_checker #(
  parameter int CAPACITY = 64
) (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  input  wire               in_stall,
  input  ism_pkg::ism_in_t  in_data,
  input  wire               out_valid,
  input  wire               out_stall,
  input  ism_pkg::ism_out_t out_data,
  output int                fail_count,
  output int                outstanding,
  output int                items_seen,
  output int                results_seen,
  output int                sets_seen,
  output int                overflow_sets
);
  timeunit 1ns;
  timeprecision 1ps;
  import ism_pkg::*;

  logic [FIELD_BITS-1:0] span_lo [CAPACITY];
  logic [FIELD_BITS-1:0] span_hi [CAPACITY];
  int                    held;
  logic                  dropped;
  ism_out_t              merged_q [$];

  task automatic note_fail(string msg);
    fail_count++;
    if (fail_count <= 10) $display("[%0t] MISMATCH: %s", $realtime, msg);
  endtask

  // Store one interval of the current set; on the last one, sort and merge.
  task automatic take_interval(ism_in_t it);
    logic [FIELD_BITS-1:0] lo, hi, key_lo, key_hi, run_lo, run_hi;
    int j;
    ism_out_t res;
    lo = it.start_point;
    hi = it.end_point;
    if (hi < lo) hi = lo;
    if (held < CAPACITY) begin
      span_lo[held] = lo;
      span_hi[held] = hi;
      held++;
    end else begin
      dropped = 1'b1;
    end
    if (!it.final_item) return;

    for (int i = 1; i < held; i++) begin
      key_lo = span_lo[i];
      key_hi = span_hi[i];
      j = i;
      while (j > 0 && span_lo[j-1] > key_lo) begin
        span_lo[j] = span_lo[j-1];
        span_hi[j] = span_hi[j-1];
        j--;
      end
      span_lo[j] = key_lo;
      span_hi[j] = key_hi;
    end

    run_lo = span_lo[0];
    run_hi = span_hi[0];
    for (int i = 1; i < held; i++) begin
      if (span_lo[i] <= run_hi) begin
        if (span_hi[i] > run_hi) run_hi = span_hi[i];
      end else begin
        res = '{merged_start: run_lo, merged_end: run_hi,
                final_result: 1'b0, overflowed: dropped};
        merged_q = {merged_q, res};
        run_lo = span_lo[i];
        run_hi = span_hi[i];
      end
    end
    res = '{merged_start: run_lo, merged_end: run_hi,
            final_result: 1'b1, overflowed: dropped};
    merged_q = {merged_q, res};
    sets_seen++;
    if (dropped) overflow_sets++;
    held    = 0;
    dropped = 1'b0;
  endtask

  always @(posedge clk) begin
    ism_out_t want;
    if (!rst_n) begin
      held          = 0;
      dropped       = 1'b0;
      fail_count    = 0;
      items_seen    = 0;
      results_seen  = 0;
      sets_seen     = 0;
      overflow_sets = 0;
      merged_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (merged_q.size() == 0) begin
          note_fail($sformatf("unexpected result start %h end %h last %b ovf %b",
                              out_data.merged_start, out_data.merged_end,
                              out_data.final_result, out_data.overflowed));
        end else begin
          want = merged_q.pop_front();
          if (out_data.merged_start !== want.merged_start ||
              out_data.merged_end   !== want.merged_end   ||
              out_data.final_result !== want.final_result ||
              out_data.overflowed   !== want.overflowed) begin
            note_fail($sformatf({"result %0d: expected start %h end %h last %b ovf %b,",
                                 " got start %h end %h last %b ovf %b"},
                                results_seen, want.merged_start, want.merged_end,
                                want.final_result, want.overflowed,
                                out_data.merged_start, out_data.merged_end,
                                out_data.final_result, out_data.overflowed));
          end
        end
      end
      if (in_valid && !in_stall) begin
        items_seen++;
        take_interval(in_data);
      end
    end
    // registered so the stimulus side reads a settled value after each edge
    outstanding <= merged_q.size();
  end

endmodule

`default_nettype wire

// ----- test/interval_sort_merge_top_tb.sv -----
// Testbench top for the interval sort and merge block: stimulus, stall patterns and verdict.
`default_nettype none

module interval_sort_merge_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ism_pkg::*;

  localparam int TOTAL_ITEMS = 310;
  localparam int HOLD_CYCLES = 300;
  localparam int CAPACITY    = 64;

  typedef enum int {DENSE, WIDE, DISJOINT, SAME_START} set_style_e;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  ism_in_t  in_data   = '0;
  logic     out_stall = 1'b0;
  logic     in_stall;
  logic     out_valid;
  ism_out_t out_data;

  int fail_count, outstanding, items_seen, results_seen, sets_seen, overflow_sets;
  int items_sent = 0;
  int burst_left = 0;
  bit gaps_on    = 1'b1;
  bit hold_req   = 1'b0;

  interval_sort_merge_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  interval_sort_merge_checker #(.CAPACITY(CAPACITY)) merge_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data),
    .fail_count    (fail_count),
    .outstanding   (outstanding),
    .items_seen    (items_seen),
    .results_seen  (results_seen),
    .sets_seen     (sets_seen),
    .overflow_sets (overflow_sets)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Offer one interval, with a random gap before each burst when gaps are on, and hold it until taken.
  task automatic send_item(ism_in_t it);
    if (burst_left == 0) begin
      if (gaps_on) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    burst_left--;
    items_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic send_set(int count, set_style_e style);
    ism_in_t it;
    int base, w, slot, s;
    case ($urandom_range(0, 3))
      0:       base = 0;
      1:       base = 65535 - 300;
      default: base = $urandom_range(0, 65535 - 300);
    endcase
    w = 65536 / count;
    for (int i = 0; i < count; i++) begin
      case (style)
        DENSE: begin
          it.start_point = 16'(base + $urandom_range(0, 255));
          it.end_point   = 16'(it.start_point + $urandom_range(0, 40));
          if ($urandom_range(0, 7) == 0) it.end_point = 16'($urandom_range(0, it.start_point));
        end
        WIDE: begin
          it.start_point = 16'($urandom);
          it.end_point   = 16'($urandom);
        end
        DISJOINT: begin
          // descending arrival, gaps wide enough that nothing merges
          slot = count - 1 - i;
          s    = slot * w + $urandom_range(0, w / 2 - 1);
          it.start_point = 16'(s);
          it.end_point   = 16'(s + $urandom_range(0, w / 2 - 1));
        end
        default: begin
          it.start_point = 16'(base);
          it.end_point   = 16'($urandom);
        end
      endcase
      it.final_item = (i == count - 1);
      send_item(it);
    end
  endtask

  // Receiver: changing stall modes, plus one long hold-off on request.
  initial begin
    int mode, span_left;
    span_left = 0;
    mode      = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if (span_left == 0) begin
        mode      = $urandom_range(0, 2);
        span_left = $urandom_range(20, 120);
      end
      span_left--;
      case (mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= $urandom_range(0, 1);
        default: out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // single intervals at the coordinate extremes, incl. end below start
    send_item('{16'd0,     16'd0,     1'b1});
    send_item('{16'hffff,  16'hffff,  1'b1});
    send_item('{16'hffff,  16'd0,     1'b1});
    send_item('{16'd0,     16'hffff,  1'b1});
    // reverse order, touching, adjacent, equal starts, end below start
    send_item('{16'd100,   16'd200,   1'b0});
    send_item('{16'd50,    16'd60,    1'b0});
    send_item('{16'd60,    16'd70,    1'b0});
    send_item('{16'd71,    16'd80,    1'b0});
    send_item('{16'd100,   16'd150,   1'b0});
    send_item('{16'd300,   16'd250,   1'b0});
    send_item('{16'd200,   16'd210,   1'b0});
    send_item('{16'd0,     16'd5,     1'b1});
    // nested intervals
    send_item('{16'd10,    16'd1000,  1'b0});
    send_item('{16'd20,    16'd30,    1'b0});
    send_item('{16'd40,    16'd50,    1'b1});
    // alternating bit patterns
    send_item('{16'h5555,  16'haaaa,  1'b0});
    send_item('{16'haaaa,  16'h5555,  1'b0});
    send_item('{16'hffff,  16'h0000,  1'b1});
    wait_drained();

    // long output hold-off while intervals keep coming back to back
    hold_req = 1'b1;
    gaps_on  = 1'b0;
    repeat (8) send_set($urandom_range(1, 6), DENSE);
    gaps_on = 1'b1;

    // full store with every interval separate, then a set that overflows the store
    send_set(CAPACITY, DISJOINT);
    send_set(CAPACITY + 2, DENSE);
    wait_drained();

    while (items_sent < TOTAL_ITEMS) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      send_set($urandom_range(1, 8), set_style_e'($urandom_range(0, 3)));
      if ($urandom_range(0, 9) == 0) wait_drained();
    end

    wait_drained();
    repeat (CAPACITY + 20) @(posedge clk);
    $display("Run covered %0d intervals in %0d sets (%0d overflowing the store), %0d results.",
             items_seen, sets_seen, overflow_sets, results_seen);
    $display("Output held off for %0d cycles once; %0d mismatches counted.",
             HOLD_CYCLES, fail_count);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("Timed out with %0d results still awaited.", outstanding);
    $display("Simulation FAILED");
    $finish;
  end

endmodule

`default_nettype wire

// ----- sim.f -----
hw/rtl/ism_pkg.sv
hw/rtl/ism_ctrl.sv
hw/rtl/ism_dp.sv
hw/rtl/interval_sort_merge_top.sv
test/interval_sort_merge_checker.sv
test/interval_sort_merge_top_tb.sv
